/* hdl/uuidp_pkg.sv */
// Shared constants, types and the hex digit decoder of the UUID text parser.
package uuidp_pkg;

  localparam logic [7:0] CHAR_DASH = 8'h2D;

  localparam logic [5:0] STRICT_LEN = 6'd36;
  localparam logic [5:0] MIN_LEN    = 6'd9;
  localparam logic [5:0] CC_MAX     = 6'd63;
  localparam logic [5:0] DASH_POS_0 = 6'd8;
  localparam logic [5:0] DASH_POS_1 = 6'd13;
  localparam logic [5:0] DASH_POS_2 = 6'd18;
  localparam logic [5:0] DASH_POS_3 = 6'd23;

  localparam logic [2:0] GROUP_FIRST = 3'd0;
  localparam logic [2:0] GROUP_MID_END = 3'd3;
  localparam logic [2:0] GROUP_LAST  = 3'd4;

  localparam logic [3:0] LIMIT_FIRST = 4'd8;
  localparam logic [3:0] LIMIT_MID   = 4'd4;
  localparam logic [3:0] LIMIT_LAST  = 4'd12;
  localparam logic [3:0] GL_MAX      = 4'd15;

  localparam logic [63:0] VER_MASK = 64'h0000_0000_0000_F000;
  localparam logic [63:0] VER_BITS = 64'h0000_0000_0000_4000;
  localparam logic [63:0] VAR_MASK = 64'hC000_0000_0000_0000;
  localparam logic [63:0] VAR_BITS = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic        is_hex;
    logic [3:0]  value;
  } hex_t;

  // Text check and assembled identifier, valid on the step of the last character.
  typedef struct packed {
    logic        fmt_ok;
    logic [63:0] id_high;
    logic [63:0] id_low;
  } scan_res_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.is_hex = 1'b1;
    h.value  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h37);
    end else begin
      h.is_hex = 1'b0;
    end
    return h;
  endfunction

endpackage

/* hdl/uuidp_scan.sv */
// Per-character scanner: group registers, counters and the text format check.
module uuidp_scan import uuidp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] text_char,
  input  logic       is_last,
  input  logic       strict_mode,
  output scan_res_t  res
);

  logic [5:0]  char_count, char_count_next;
  logic [2:0]  group_index, group_index_next;
  logic [3:0]  group_length, group_length_next;
  logic        bad_text, bad_text_next;
  logic [31:0] first_group, first_group_next;
  logic [15:0] middle_groups [3];
  logic [15:0] middle_groups_next [3];
  logic [47:0] last_group, last_group_next;

  hex_t        hex;
  logic        dash_pos;
  logic        is_dash;
  logic [3:0]  limit;
  logic        len_ok;

  always_comb begin
    hex      = hex_decode(text_char);
    is_dash  = (text_char == CHAR_DASH);
    dash_pos = (char_count == DASH_POS_0) || (char_count == DASH_POS_1) ||
               (char_count == DASH_POS_2) || (char_count == DASH_POS_3);

    priority if (group_index == GROUP_FIRST) begin
      limit = LIMIT_FIRST;
    end else if (group_index <= GROUP_MID_END) begin
      limit = LIMIT_MID;
    end else begin
      limit = LIMIT_LAST;
    end

    char_count_next   = (char_count == CC_MAX) ? char_count : char_count + 6'd1;
    group_index_next  = group_index;
    group_length_next = group_length;
    bad_text_next     = bad_text;
    first_group_next  = first_group;
    last_group_next   = last_group;
    for (int k = 0; k < 3; k++) begin
      middle_groups_next[k] = middle_groups[k];
    end

    if (is_dash) begin
      if (strict_mode && !dash_pos) begin
        bad_text_next = 1'b1;
      end
      // A dash after the fifth group has started ends nothing: mark bad.
      if (group_index >= GROUP_LAST) begin
        bad_text_next = 1'b1;
      end else begin
        group_index_next  = group_index + 3'd1;
        group_length_next = 4'd0;
      end
    end else if (hex.is_hex) begin
      if (strict_mode && dash_pos) begin
        bad_text_next = 1'b1;
      end
      if (group_length >= limit) begin
        bad_text_next = 1'b1;
      end
      if (group_length != GL_MAX) begin
        group_length_next = group_length + 4'd1;
      end
      priority if (group_index == GROUP_FIRST) begin
        first_group_next = {first_group[27:0], hex.value};
      end else if (group_index <= GROUP_MID_END) begin
        for (int k = 0; k < 3; k++) begin
          if (group_index == 3'(k + 1)) begin
            middle_groups_next[k] = {middle_groups[k][11:0], hex.value};
          end
        end
      end else begin
        last_group_next = {last_group[43:0], hex.value};
      end
    end else begin
      bad_text_next = 1'b1;
    end

    len_ok = strict_mode ? (char_count_next == STRICT_LEN) : (char_count_next >= MIN_LEN);
    res.fmt_ok  = !bad_text_next && (group_index_next == GROUP_LAST) && len_ok;
    res.id_high = {first_group_next, middle_groups_next[0], middle_groups_next[1]};
    res.id_low  = {middle_groups_next[2], last_group_next};
  end

  always_ff @(posedge clk) begin
    if (rst || (step && is_last)) begin
      char_count   <= '0;
      group_index  <= '0;
      group_length <= '0;
      bad_text     <= 1'b0;
      first_group  <= '0;
      last_group   <= '0;
      for (int k = 0; k < 3; k++) begin
        middle_groups[k] <= '0;
      end
    end else if (step) begin
      char_count   <= char_count_next;
      group_index  <= group_index_next;
      group_length <= group_length_next;
      bad_text     <= bad_text_next;
      first_group  <= first_group_next;
      last_group   <= last_group_next;
      for (int k = 0; k < 3; k++) begin
        middle_groups[k] <= middle_groups_next[k];
      end
    end
  end

endmodule

/* hdl/uuid_text_parser.sv */
// UUID text parser: one character per cycle unless stalled; reports the parse on the last.
// The text streams in one character per transfer, one transfer per cycle at full rate,
// with tlast on the final character. Each character sits in an input register and is
// then scanned into the group registers; only the last character of a text produces a
// result, which is loaded into the output register as that character is scanned and
// holds until taken. tuser[0] is set when the text was a valid nil or version 4 UUID;
// tdata always shows the stored identifier, which changes only on a successful parse.
// strict_mode may be written only while no text is in flight.
module uuid_text_parser import uuidp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_data,       // strict_mode
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // text_char
  input  logic         s_axis_tlast,   // is_last
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // id_high [63:0], id_low [127:64]
  output logic [0:0]   m_axis_tuser    // parse_ok
);

  logic        strict_mode;
  logic        a_valid;
  logic [7:0]  a_char;
  logic        a_last;
  logic        step;
  logic        load;
  logic        ok;
  logic        nonzero;
  logic [63:0] id_high;
  logic [63:0] id_low;
  scan_res_t   res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      strict_mode <= 1'b0;
    end else if (cfg_valid) begin
      strict_mode <= cfg_data[0];
    end
  end

  // Advance the input register unless its last character would overwrite a pending result.
  assign step          = a_valid && (!a_last || !m_axis_tvalid || m_axis_tready);
  assign load          = step && a_last;
  assign s_axis_tready = !a_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_axis_tready) begin
      a_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      a_char <= s_axis_tdata;
      a_last <= s_axis_tlast;
    end
  end

  uuidp_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .text_char   (a_char),
    .is_last     (a_last),
    .strict_mode (strict_mode),
    .res         (res)
  );

  always_comb begin
    nonzero = (|res.id_high) || (|res.id_low);
    ok      = res.fmt_ok;
    if (nonzero) begin
      if ((res.id_high & VER_MASK) != VER_BITS) begin
        ok = 1'b0;
      end
      if ((res.id_low & VAR_MASK) != VAR_BITS) begin
        ok = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      id_high <= '0;
      id_low  <= '0;
    end else if (load && ok) begin
      id_high <= res.id_high;
      id_low  <= res.id_low;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tuser <= ok;
      m_axis_tdata <= ok ? {res.id_low, res.id_high} : {id_low, id_high};
    end
  end

  a_rise_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(load))
    else $error("result appeared without a last character");

  a_ok_shows_stored: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == {id_low, id_high}))
    else $error("successful result differs from stored identifier");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !load)
    else $error("result loaded over a pending one");

endmodule
